// ----- hdl/timer_slot_next_fit_allocator_unit_assert.svh -----
`ifndef TIMER_SLOT_NEXT_FIT_ALLOCATOR_UNIT_ASSERT_SVH
`define TIMER_SLOT_NEXT_FIT_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clock, off during reset
`define TSNFA_ASSERT_NOW(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication, clocked on clock, off during reset
`define TSNFA_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ----- hdl/tsnfa_pkg.sv -----
`timescale 1ns / 1ps

package tsnfa_pkg;

   localparam int SLOT_COUNT = 16;
   localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
   localparam int LANES      = (SLOT_COUNT < 4) ? SLOT_COUNT : 4;

   localparam int OP_W     = 2;
   localparam int IDX_W    = 6;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 3;

   typedef logic [OP_W-1:0]     op_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [1:0]          emit_type;

   localparam op_type OP_INIT  = 2'd0;
   localparam op_type OP_ALLOC = 2'd1;
   localparam op_type OP_FREE  = 2'd2;
   localparam op_type OP_SHUT  = 2'd3;

   localparam status_type ST_OK        = 3'd0;
   localparam status_type ST_NOT_READY = 3'd1;
   localparam status_type ST_ALREADY   = 3'd2;
   localparam status_type ST_FULL      = 3'd3;
   localparam status_type ST_DOUBLE    = 3'd4;
   localparam status_type ST_NOT_FOUND = 3'd5;

   localparam emit_type EM_STATUS   = 2'd0;
   localparam emit_type EM_GRANT    = 2'd1;
   localparam emit_type EM_CALLBACK = 2'd2;

   typedef struct packed {
      logic       load;
      logic       init;
      logic       free_slot;
      logic       search_start;
      logic       search_step;
      logic       commit;
      logic       scan_start;
      logic       scan_step;
      logic       clear_ready;
      logic       emit;
      emit_type   emit_kind;
      status_type emit_status;
   } cmd_type;

   typedef struct packed {
      logic ready_flag;
      logic out_free;
      logic rel_bad_index;
      logic rel_slot_free;
      logic hit;
      logic exhausted;
      logic scan_busy;
      logic scan_end;
   } stat_type;

endpackage

// ----- hdl/tsnfa_datapath.sv -----
`timescale 1ns / 1ps

module tsnfa_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  tsnfa_pkg::cmd_type            cmd,
   output tsnfa_pkg::stat_type           stat,
   input  logic [tsnfa_pkg::IDX_W-1:0]   req_slot_index,
   input  logic [tsnfa_pkg::DATA_W-1:0]  req_handler_ref,
   input  logic [tsnfa_pkg::DATA_W-1:0]  req_handler_arg,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output tsnfa_pkg::status_type         rsp_status,
   output logic [tsnfa_pkg::IDX_W-1:0]   rsp_granted_slot,
   output logic                          rsp_is_callback,
   output logic [tsnfa_pkg::DATA_W-1:0]  rsp_callback_ref,
   output logic [tsnfa_pkg::DATA_W-1:0]  rsp_callback_arg,
   output logic                          rsp_last
);
   import tsnfa_pkg::*;

   logic                  ready_ff;
   logic [SLOT_W-1:0]     last_granted_ff;
   logic [SLOT_COUNT-1:0] busy_ff;
   logic [DATA_W-1:0]     handler_ff [SLOT_COUNT];
   logic [DATA_W-1:0]     handler_arg_ff [SLOT_COUNT];
   logic [DATA_W-1:0]     ref_hold_ff;
   logic [DATA_W-1:0]     arg_hold_ff;
   logic [SLOT_W-1:0]     cursor_ff;
   logic [CNT_W-1:0]      checked_ff;
   logic [SLOT_W-1:0]     scan_ff;

   logic                  rsp_valid_ff;
   status_type            rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]      rsp_slot_ff, rsp_slot_in;
   logic                  rsp_cb_ff, rsp_cb_in;
   logic [DATA_W-1:0]     rsp_ref_ff, rsp_ref_in;
   logic [DATA_W-1:0]     rsp_arg_ff, rsp_arg_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [SLOT_W:0]       cand_sum;
   logic [SLOT_W-1:0]     cand;
   logic [SLOT_W-1:0]     last_cand;
   logic [SLOT_W-1:0]     hit_pos;
   logic                  hit;
   logic [CNT_W:0]        span;

   // next-fit window: up to LANES slots after the cursor
   always_comb begin
      hit       = 1'b0;
      hit_pos   = '0;
      cand_sum  = '0;
      cand      = '0;
      last_cand = '0;
      span      = '0;
      for (int k = 1; k <= LANES; k++) begin
         cand_sum = {1'b0, cursor_ff} + (SLOT_W + 1)'(k);
         if (cand_sum >= (SLOT_W + 1)'(SLOT_COUNT)) begin
            cand_sum = cand_sum - (SLOT_W + 1)'(SLOT_COUNT);
         end
         cand      = cand_sum[SLOT_W-1:0];
         last_cand = cand;
         span      = {1'b0, checked_ff} + (CNT_W + 1)'(k);
         if (!hit && (span <= (CNT_W + 1)'(SLOT_COUNT)) && !busy_ff[cand]) begin
            hit     = 1'b1;
            hit_pos = cand;
         end
      end
   end

   always_comb begin
      stat.ready_flag    = ready_ff;
      stat.out_free      = !rsp_valid_ff || rsp_ready;
      stat.rel_bad_index = req_slot_index >= IDX_W'(SLOT_COUNT);
      stat.rel_slot_free = !busy_ff[req_slot_index[SLOT_W-1:0]];
      stat.hit           = hit;
      stat.exhausted     = ({1'b0, checked_ff} + (CNT_W + 1)'(LANES))
                           >= (CNT_W + 1)'(SLOT_COUNT);
      stat.scan_busy     = busy_ff[scan_ff];
      stat.scan_end      = scan_ff == SLOT_W'(SLOT_COUNT - 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff        <= 1'b0;
         last_granted_ff <= SLOT_W'(SLOT_COUNT - 1);
      end else begin
         if (cmd.init) begin
            ready_ff <= 1'b1;
         end else if (cmd.clear_ready) begin
            ready_ff <= 1'b0;
         end
         if (cmd.commit) begin
            last_granted_ff <= hit_pos;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.init) begin
         busy_ff <= '0;
      end else if (cmd.commit) begin
         busy_ff[hit_pos] <= 1'b1;
      end else if (cmd.free_slot) begin
         busy_ff[req_slot_index[SLOT_W-1:0]] <= 1'b0;
      end
      if (cmd.commit) begin
         handler_ff[hit_pos]     <= ref_hold_ff;
         handler_arg_ff[hit_pos] <= arg_hold_ff;
      end
      if (cmd.load) begin
         ref_hold_ff <= req_handler_ref;
         arg_hold_ff <= req_handler_arg;
      end
      if (cmd.search_start) begin
         cursor_ff  <= last_granted_ff;
         checked_ff <= '0;
      end else if (cmd.search_step) begin
         cursor_ff  <= last_cand;
         checked_ff <= checked_ff + CNT_W'(LANES);
      end
      if (cmd.scan_start) begin
         scan_ff <= '0;
      end else if (cmd.scan_step) begin
         scan_ff <= scan_ff + SLOT_W'(1);
      end
   end

   always_comb begin
      rsp_status_in = cmd.emit_status;
      rsp_slot_in   = '0;
      rsp_cb_in     = 1'b0;
      rsp_ref_in    = '0;
      rsp_arg_in    = '0;
      rsp_last_in   = 1'b1;
      case (cmd.emit_kind)
         EM_GRANT: begin
            rsp_status_in = ST_OK;
            rsp_slot_in   = IDX_W'(hit_pos);
         end
         EM_CALLBACK: begin
            rsp_status_in = ST_OK;
            rsp_slot_in   = IDX_W'(scan_ff);
            rsp_cb_in     = 1'b1;
            rsp_ref_in    = handler_ff[scan_ff];
            rsp_arg_in    = handler_arg_ff[scan_ff];
            rsp_last_in   = 1'b0;
         end
         default: begin
            rsp_status_in = cmd.emit_status;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_cb_ff     <= rsp_cb_in;
         rsp_ref_ff    <= rsp_ref_in;
         rsp_arg_ff    <= rsp_arg_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_granted_slot = rsp_slot_ff;
   assign rsp_is_callback  = rsp_cb_ff;
   assign rsp_callback_ref = rsp_ref_ff;
   assign rsp_callback_arg = rsp_arg_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

// ----- hdl/tsnfa_ctrl.sv -----
`timescale 1ns / 1ps

module tsnfa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  tsnfa_pkg::op_type    req_operation,
   output logic                 req_ready,
   input  tsnfa_pkg::stat_type  stat,
   output tsnfa_pkg::cmd_type   cmd
);
   import tsnfa_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SEARCH = 2'd1;
   localparam logic [1:0] S_SCAN   = 2'd2;
   localparam logic [1:0] S_CLOSE  = 2'd3;

   logic [1:0] state_ff, state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = stat.out_free;
            if (req_valid && stat.out_free) begin
               cmd.emit_kind = EM_STATUS;
               if (req_operation == OP_INIT) begin
                  cmd.emit = 1'b1;
                  if (stat.ready_flag) begin
                     cmd.emit_status = ST_ALREADY;
                  end else begin
                     cmd.init        = 1'b1;
                     cmd.emit_status = ST_OK;
                  end
               end else if (!stat.ready_flag) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_status = ST_NOT_READY;
               end else begin
                  case (req_operation)
                     OP_ALLOC: begin
                        cmd.load         = 1'b1;
                        cmd.search_start = 1'b1;
                        state_in         = S_SEARCH;
                     end
                     OP_FREE: begin
                        cmd.emit = 1'b1;
                        if (stat.rel_bad_index) begin
                           cmd.emit_status = ST_NOT_FOUND;
                        end else if (stat.rel_slot_free) begin
                           cmd.emit_status = ST_DOUBLE;
                        end else begin
                           cmd.free_slot   = 1'b1;
                           cmd.emit_status = ST_OK;
                        end
                     end
                     default: begin
                        cmd.scan_start = 1'b1;
                        state_in       = S_SCAN;
                     end
                  endcase
               end
            end
         end
         S_SEARCH: begin
            if (stat.hit) begin
               cmd.commit    = 1'b1;
               cmd.emit      = 1'b1;
               cmd.emit_kind = EM_GRANT;
               state_in      = S_IDLE;
            end else if (stat.exhausted) begin
               cmd.emit        = 1'b1;
               cmd.emit_kind   = EM_STATUS;
               cmd.emit_status = ST_FULL;
               state_in        = S_IDLE;
            end else begin
               cmd.search_step = 1'b1;
            end
         end
         S_SCAN: begin
            if (!stat.scan_busy || stat.out_free) begin
               if (stat.scan_busy) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = EM_CALLBACK;
               end
               if (stat.scan_end) begin
                  state_in = S_CLOSE;
               end else begin
                  cmd.scan_step = 1'b1;
               end
            end
         end
         S_CLOSE: begin
            if (stat.out_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_kind   = EM_STATUS;
               cmd.emit_status = ST_OK;
               cmd.clear_ready = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`include "timer_slot_next_fit_allocator_unit_assert.svh"

   `TSNFA_ASSERT_NOW(a_search_out_empty, state_ff == S_SEARCH, stat.out_free, "search with result pending")
   `TSNFA_ASSERT_NOW(a_emit_room, cmd.emit, stat.out_free, "result emitted over a pending one")
   `TSNFA_ASSERT_NEXT(a_init_sets_ready, cmd.init, stat.ready_flag, "init did not set ready")
   `TSNFA_ASSERT_NEXT(a_shut_clears_ready, cmd.clear_ready, !stat.ready_flag, "ready not cleared")

endmodule

// ----- hdl/timer_slot_next_fit_allocator_unit.sv -----
`timescale 1ns / 1ps

// Next-fit allocator over a table of SLOT_COUNT timer slots (init, allocate, release,
// shutdown). For init, release and every error reply but the full reply of allocate,
// the item is accepted and its result is registered at the same edge. Allocate searches
// from the slot after the last granted one, and the search unit checks four slots per
// cycle. Shutdown walks the table one slot per cycle, stalling while a callback result
// waits to be taken. A new item is accepted once the block is back in its idle state
// and the output register is empty or being read.
module timer_slot_next_fit_allocator_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  tsnfa_pkg::op_type             req_operation,
   input  logic [tsnfa_pkg::IDX_W-1:0]   req_slot_index,
   input  logic [tsnfa_pkg::DATA_W-1:0]  req_handler_ref,
   input  logic [tsnfa_pkg::DATA_W-1:0]  req_handler_arg,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output tsnfa_pkg::status_type         rsp_status,
   output logic [tsnfa_pkg::IDX_W-1:0]   rsp_granted_slot,
   output logic                          rsp_is_callback,
   output logic [tsnfa_pkg::DATA_W-1:0]  rsp_callback_ref,
   output logic [tsnfa_pkg::DATA_W-1:0]  rsp_callback_arg,
   output logic                          rsp_last
);
   import tsnfa_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   tsnfa_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_ready     (req_ready),
      .stat          (stat),
      .cmd           (cmd)
   );

   tsnfa_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_slot_index   (req_slot_index),
      .req_handler_ref  (req_handler_ref),
      .req_handler_arg  (req_handler_arg),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_granted_slot (rsp_granted_slot),
      .rsp_is_callback  (rsp_is_callback),
      .rsp_callback_ref (rsp_callback_ref),
      .rsp_callback_arg (rsp_callback_arg),
      .rsp_last         (rsp_last)
   );

endmodule
